// ===== hw/rtl/rrw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrw_pkg: shared definitions of the receive reorder window
// Request and response payloads, window entry layout, controller/datapath
// command and status groups, and the result codes.
// ----------------------------------------------------------------------------
package rrw_pkg;

   localparam int SEQ_W  = 16;
   localparam int DATA_W = 16;
   localparam int LEN_W  = 2;

   localparam int WINDOW_DEPTH_DEF = 32;
   localparam int CHUNK_BYTES      = 2;

   localparam logic [SEQ_W-1:0] SEQ_MAX    = 16'hFFFF;
   localparam logic [SEQ_W-1:0] HALF_RANGE = SEQ_W'(SEQ_MAX / 2);

   // Largest valid length: the smaller of the chunk size and the payload bytes.
   localparam int LEN_LIMIT_INT = (CHUNK_BYTES < DATA_W / 8) ? CHUNK_BYTES : DATA_W / 8;
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LEN_LIMIT_INT);

   localparam logic [LEN_W-1:0] LEN_NONE = 2'd0;
   localparam logic [LEN_W-1:0] LEN_ONE  = 2'd1;

   localparam logic [1:0] ST_ACCEPTED = 2'd0;
   localparam logic [1:0] ST_DUP_PAST = 2'd1;
   localparam logic [1:0] ST_OUTSIDE  = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic KIND_STATUS   = 1'b0;
   localparam logic KIND_DELIVERY = 1'b1;

   typedef struct packed {
      logic [SEQ_W-1:0]  sequence_req;
      logic [DATA_W-1:0] chunk_data;
      logic [LEN_W-1:0]  chunk_length;
      logic              command_flag;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [1:0]        status;
      logic              ack_valid;
      logic [SEQ_W-1:0]  ack_sequence;
      logic [DATA_W-1:0] out_data;
      logic [LEN_W-1:0]  out_length;
      logic              out_command;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [SEQ_W-1:0]  seq;
      logic [DATA_W-1:0] data;
      logic [LEN_W-1:0]  len;
      logic              cmd;
   } entry_type;

   typedef struct packed {
      logic clear;     // write one empty entry of the clearing pass
      logic capture;   // take the request, read its slot
      logic classify;  // classify the request, build its status result
      logic fetch;     // read the slot of the next expected sequence
      logic retire;    // hand the pending result to the output register
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic hit;
      logic out_free;
   } dp_stat_type;

endpackage
`default_nettype wire

// ===== hw/rtl/rrw_chan_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrw_chan_if: valid/ready channel
// Carries one payload per handshake from a source to a sink.
// ----------------------------------------------------------------------------
interface rrw_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rrw_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrw_ram: generic simple dual-port RAM
// One write port and one read port, read data registered and held when the
// read port is idle.
// ----------------------------------------------------------------------------
module rrw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rrw_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrw_ctrl: receive reorder window controller
// Sequences the clearing pass, the lookup of a request and the in-order
// delivery loop.
// ----------------------------------------------------------------------------
module rrw_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire rrw_pkg::dp_stat_type stat,
   output rrw_pkg::dp_cmd_type      cmd
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_LOOK  = 3'd2;
   localparam logic [2:0] S_FETCH = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.classify = 1'b1;
            state_in     = S_FETCH;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            // A hit keeps the loop here: the datapath already reads the next slot.
            cmd.retire = stat.out_free;
            if (stat.out_free && !stat.hit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/rrw_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrw_datapath: receive reorder window datapath
// Window store, expected sequence tracking, classification and the output
// register.
// ----------------------------------------------------------------------------
module rrw_datapath #(
   parameter int WINDOW_DEPTH = rrw_pkg::WINDOW_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rrw_pkg::req_type     req_payload,
   input  wire rrw_pkg::dp_cmd_type  cmd,
   output rrw_pkg::dp_stat_type      stat,
   output logic                      rsp_valid,
   output rrw_pkg::rsp_type          rsp_payload,
   input  wire logic                 rsp_ready
);

   localparam int IDX_W = $clog2(WINDOW_DEPTH);
   localparam logic [IDX_W-1:0]  TOP_SLOT  = IDX_W'(WINDOW_DEPTH - 1);
   localparam logic [IDX_W:0]    DEPTH_SUM = (IDX_W + 1)'(WINDOW_DEPTH);
   localparam logic [rrw_pkg::SEQ_W-1:0] DEPTH_SEQ = rrw_pkg::SEQ_W'(WINDOW_DEPTH);

   // Expected sequence and its slot, kept side by side so no modulo is needed.
   logic [rrw_pkg::SEQ_W-1:0] next_exp_ff, next_exp_in;
   logic [IDX_W-1:0]          next_slot_ff, next_slot_in;
   logic [IDX_W-1:0]          clr_cnt_ff, clr_cnt_in;

   // Captured request.
   logic [rrw_pkg::SEQ_W-1:0]  seq_ff;
   logic [rrw_pkg::DATA_W-1:0] data_ff;
   logic [rrw_pkg::LEN_W-1:0]  len_ff;
   logic                       cmdf_ff;
   logic [IDX_W-1:0]           slot_ff;
   logic                       in_win_ff;
   logic                       past_ff;

   logic [rrw_pkg::LEN_W-1:0]  len_sat;
   logic [rrw_pkg::DATA_W-1:0] data_mask;
   logic [rrw_pkg::SEQ_W-1:0]  offset;
   logic [IDX_W:0]             slot_sum;
   logic [IDX_W:0]             slot_red;
   logic [IDX_W-1:0]           slot_in;

   rrw_pkg::rsp_type   pend_ff, pend_in;
   rrw_pkg::rsp_type   out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   rrw_pkg::entry_type rd_entry;
   rrw_pkg::entry_type wr_entry;
   logic               wr_en, rd_en;
   logic [IDX_W-1:0]   wr_addr, rd_addr;

   logic match, store, ackv, hit, advance, out_free;
   logic [1:0] status_code;

   // Request conditioning and slot of the incoming sequence.
   always_comb begin
      len_sat = (req_payload.chunk_length > rrw_pkg::LEN_LIMIT) ?
                rrw_pkg::LEN_LIMIT : req_payload.chunk_length;
      case (len_sat)
         rrw_pkg::LEN_NONE: data_mask = '0;
         rrw_pkg::LEN_ONE:  data_mask = {8'h00, req_payload.chunk_data[7:0]};
         default:           data_mask = req_payload.chunk_data;
      endcase
      offset   = req_payload.sequence_req - next_exp_ff;
      slot_sum = {1'b0, next_slot_ff} + {1'b0, offset[IDX_W-1:0]};
      slot_red = (slot_sum >= DEPTH_SUM) ? slot_sum - DEPTH_SUM : slot_sum;
      // Past the 16-bit wrap the sequence itself is below the depth.
      slot_in  = (req_payload.sequence_req < next_exp_ff) ?
                 req_payload.sequence_req[IDX_W-1:0] : slot_red[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         seq_ff    <= req_payload.sequence_req;
         data_ff   <= data_mask;
         len_ff    <= len_sat;
         cmdf_ff   <= req_payload.command_flag;
         slot_ff   <= slot_in;
         in_win_ff <= offset < DEPTH_SEQ;
         past_ff   <= offset > rrw_pkg::HALF_RANGE;
      end
   end

   // Classification against the entry read from the request's slot.
   always_comb begin
      match = rd_entry.valid && (rd_entry.seq == seq_ff);
      store = 1'b0;
      ackv  = 1'b0;
      if (in_win_ff) begin
         if (match) begin
            status_code = rrw_pkg::ST_DUP_PAST;
            ackv        = 1'b1;
         end else if (rd_entry.valid) begin
            status_code = rrw_pkg::ST_FULL;
         end else begin
            status_code = rrw_pkg::ST_ACCEPTED;
            ackv        = 1'b1;
            store       = 1'b1;
         end
      end else if (past_ff) begin
         status_code = rrw_pkg::ST_DUP_PAST;
         ackv        = 1'b1;
      end else begin
         status_code = rrw_pkg::ST_OUTSIDE;
      end
   end

   assign hit      = rd_entry.valid && (rd_entry.seq == next_exp_ff);
   assign advance  = cmd.retire && hit;
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      next_exp_in  = next_exp_ff;
      next_slot_in = next_slot_ff;
      if (advance) begin
         next_exp_in = next_exp_ff + rrw_pkg::SEQ_W'(1);
         if (next_exp_ff == rrw_pkg::SEQ_MAX || next_slot_ff == TOP_SLOT) begin
            next_slot_in = '0;
         end else begin
            next_slot_in = next_slot_ff + IDX_W'(1);
         end
      end
      clr_cnt_in = cmd.clear ? clr_cnt_ff + IDX_W'(1) : clr_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_exp_ff  <= '0;
         next_slot_ff <= '0;
         clr_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         next_exp_ff  <= next_exp_in;
         next_slot_ff <= next_slot_in;
         clr_cnt_ff   <= clr_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Pending result and output register.
   always_comb begin
      pend_in = pend_ff;
      if (cmd.classify) begin
         pend_in              = '0;
         pend_in.kind         = rrw_pkg::KIND_STATUS;
         pend_in.status       = status_code;
         pend_in.ack_valid    = ackv;
         pend_in.ack_sequence = ackv ? seq_ff : '0;
      end else if (advance) begin
         pend_in             = '0;
         pend_in.kind        = rrw_pkg::KIND_DELIVERY;
         pend_in.status      = rrw_pkg::ST_ACCEPTED;
         pend_in.out_data    = rd_entry.data;
         pend_in.out_length  = rd_entry.len;
         pend_in.out_command = rd_entry.cmd;
      end
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.retire) begin
         out_in       = pend_ff;
         out_in.last  = !hit;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   // Window store ports.
   always_comb begin
      rd_en   = cmd.capture || cmd.fetch || advance;
      rd_addr = cmd.capture ? slot_in : (advance ? next_slot_in : next_slot_ff);
      wr_en   = cmd.clear || (cmd.classify && store) || advance;
      wr_addr = cmd.clear ? clr_cnt_ff : (cmd.classify ? slot_ff : next_slot_ff);
      wr_entry = '0;
      if (cmd.classify) begin
         wr_entry.valid = 1'b1;
         wr_entry.seq   = seq_ff;
         wr_entry.data  = data_ff;
         wr_entry.len   = len_ff;
         wr_entry.cmd   = cmdf_ff;
      end
   end

   rrw_ram #(
      .WIDTH ($bits(rrw_pkg::entry_type)),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign stat.clear_done = (clr_cnt_ff == TOP_SLOT);
   assign stat.hit        = hit;
   assign stat.out_free   = out_free;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

`ifndef SYNTH
   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      next_slot_ff <= TOP_SLOT)
      else $error("expected slot index beyond window depth");

   a_advance_by_one: assert property (@(posedge clock) disable iff (reset)
      advance |=> next_exp_ff == $past(next_exp_ff) + rrw_pkg::SEQ_W'(1))
      else $error("expected sequence did not advance by one on delivery");

   a_status_ack: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.kind == rrw_pkg::KIND_STATUS) |->
      (out_ff.ack_valid == (out_ff.status == rrw_pkg::ST_ACCEPTED ||
                            out_ff.status == rrw_pkg::ST_DUP_PAST)))
      else $error("acknowledge flag disagrees with status");

   a_delivery_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.kind == rrw_pkg::KIND_DELIVERY) |->
      (!out_ff.ack_valid && out_ff.status == rrw_pkg::ST_ACCEPTED))
      else $error("delivery carries status or acknowledge");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/receive_reorder_window.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// receive_reorder_window: selective-repeat receive window
// Classifies each received chunk against the next expected sequence, stores
// new chunks in a window RAM and delivers stored chunks in sequence order.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   req_chan  in         valid / ready          sequence, data, length, command
//   rsp_chan  out        valid / ready          status or delivered chunk, last
//
// Sequence: a request passes through the accept, lookup, fetch and check steps,
// and the check step repeats for each chunk it releases in order; the delivery
// loop is bound by the single read port of the window RAM.
// Reset: after reset a clearing pass writes every window entry empty, with
// req_chan.ready low.
// Stalls: results leave through one output register; while rsp_chan is held
// the check step waits and no new request is taken.
//
module receive_reorder_window #(
   parameter int WINDOW_DEPTH = rrw_pkg::WINDOW_DEPTH_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   rrw_chan_if.sink   req_chan,
   rrw_chan_if.source rsp_chan
);

   // Command and status groups between the controller and the datapath.
   rrw_pkg::dp_cmd_type  cmd;
   rrw_pkg::dp_stat_type stat;

   // The controller owns the request handshake: a request is taken only when
   // the block is idle, that is after the previous request has handed its last
   // result to the output register.
   rrw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the window RAM, the expected sequence and its slot,
   // the pending result and the output register that drives rsp_chan. Each
   // request first yields its status result; the last flag of a result is
   // fixed once the following slot lookup shows whether a delivery follows.
   rrw_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_chan.payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_chan.valid),
      .rsp_payload (rsp_chan.payload),
      .rsp_ready   (rsp_chan.ready)
   );

endmodule
`default_nettype wire
